### src/ihc_pkg.sv
// ihc_pkg: shared types and constants for the ipv4 header check core
// used by ihc_front, ihc_back and ipv4_header_check_core
package ihc_pkg;

   localparam int FRONT_QUEUE_DEPTH  = 4;
   localparam int RESULT_QUEUE_DEPTH = 2;

   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [15:0] MIN_HEADER_LEN = 16'd20;
   localparam logic [3:0]  IP_VERSION     = 4'd4;
   localparam logic [3:0]  MIN_HEADER_WDS = 4'd5;
   localparam logic [15:0] TTL_INDEX      = 16'd8;
   localparam logic [15:0] DEST_FIRST     = 16'd16;
   localparam logic [15:0] DEST_LAST      = 16'd19;
   localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
   localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_ACCEPT   = 3'd0,
      ST_TTL      = 3'd1,
      ST_VERSION  = 3'd2,
      ST_HEADLEN  = 3'd3,
      ST_DEST     = 3'd4,
      ST_CHECKSUM = 3'd5,
      ST_TRUNC    = 3'd6
   } status_type;

   // one classified byte handed from front to back
   typedef struct packed {
      logic [7:0]  data;
      logic        first;
      logic        ttl_pos;
      logic        dest_pos;
      logic        sum_hi;
      logic        sum_lo;
      logic        last;
      logic        trunc;
      logic        hlen_bad;
      logic [15:0] length;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] length;
   } result_type;

endpackage

### src/ihc_fifo.sv
// ihc_fifo: small register queue with full and empty flags
// no package dependency; used between front and back and for results
module ihc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/ihc_front.sv
// ihc_front: counts request bytes and tags each with its header role
// depends on ihc_pkg
module ihc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output ihc_pkg::item_type item
);
   import ihc_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [3:0]  hw_ff, hw_in;
   logic [3:0]  hw_cur;
   logic [15:0] hdr_bytes;
   logic [15:0] len;
   logic        first;
   logic        in_header;

   assign first     = (count_ff == '0);
   assign hw_cur    = first ? data_byte[3:0] : hw_ff;
   assign hdr_bytes = {10'd0, hw_cur, 2'b00};
   assign in_header = (count_ff < hdr_bytes);
   assign len       = (count_ff < COUNT_MAX) ? count_ff + 16'd1 : count_ff;

   always_comb begin
      item.data     = data_byte;
      item.first    = first;
      item.ttl_pos  = (count_ff == TTL_INDEX);
      item.dest_pos = (count_ff >= DEST_FIRST) && (count_ff <= DEST_LAST);
      item.sum_hi   = in_header && !count_ff[0];
      item.sum_lo   = in_header && count_ff[0];
      item.last     = last_byte;
      item.trunc    = (len < MIN_HEADER_LEN) || (len < hdr_bytes);
      item.hlen_bad = (hw_cur < MIN_HEADER_WDS);
      item.length   = len;
   end

   always_comb begin
      count_in = count_ff;
      hw_in    = hw_ff;
      if (accept) begin
         if (last_byte) begin
            count_in = '0;
            hw_in    = '0;
         end else begin
            count_in = len;
            hw_in    = hw_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hw_ff    <= '0;
      end else begin
         count_ff <= count_in;
         hw_ff    <= hw_in;
      end
   end

endmodule

### src/ihc_back.sv
// ihc_back: applies classified bytes to header state and forms the verdict
// depends on ihc_pkg
module ihc_back (
   input  logic                clock,
   input  logic                reset,
   input  ihc_pkg::item_type   item,
   input  logic                item_valid,
   output logic                item_pop,
   input  logic [31:0]         local_address,
   input  logic                res_full,
   output logic                res_push,
   output ihc_pkg::result_type result
);
   import ihc_pkg::*;

   logic [3:0]  ver_ff, ver_in, ver_cur;
   logic        ttl_ff, ttl_in, ttl_cur;
   logic [31:0] dest_ff, dest_in, dest_cur;
   logic [15:0] sum_ff, sum_in, sum_cur;
   logic [7:0]  hold_ff, hold_in, hold_cur;
   logic [16:0] sum_wide;

   assign item_pop = item_valid && !res_full;
   assign res_push = item_pop && item.last;

   assign ver_cur  = item.first ? item.data[7:4] : ver_ff;
   assign ttl_cur  = item.ttl_pos ? (item.data == 8'd0) : ttl_ff;
   assign dest_cur = item.dest_pos ? {dest_ff[23:0], item.data} : dest_ff;
   assign hold_cur = item.sum_hi ? item.data : hold_ff;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, hold_ff, item.data};
   assign sum_cur  = item.sum_lo ? sum_wide[15:0] + {15'd0, sum_wide[16]} : sum_ff;

   always_comb begin
      result.length = item.length;
      if (item.trunc) begin
         result.status = ST_TRUNC;
      end else if (ttl_cur) begin
         result.status = ST_TTL;
      end else if (ver_cur != IP_VERSION) begin
         result.status = ST_VERSION;
      end else if (item.hlen_bad) begin
         result.status = ST_HEADLEN;
      end else if (dest_cur != local_address && dest_cur != BROADCAST_ADDR) begin
         result.status = ST_DEST;
      end else if (sum_cur != SUM_GOOD) begin
         result.status = ST_CHECKSUM;
      end else begin
         result.status = ST_ACCEPT;
      end
   end

   always_comb begin
      ver_in  = ver_ff;
      ttl_in  = ttl_ff;
      dest_in = dest_ff;
      sum_in  = sum_ff;
      hold_in = hold_ff;
      if (item_pop) begin
         if (item.last) begin
            ver_in  = '0;
            ttl_in  = 1'b0;
            dest_in = '0;
            sum_in  = '0;
            hold_in = '0;
         end else begin
            ver_in  = ver_cur;
            ttl_in  = ttl_cur;
            dest_in = dest_cur;
            sum_in  = sum_cur;
            hold_in = hold_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff  <= '0;
         ttl_ff  <= 1'b0;
         dest_ff <= '0;
         sum_ff  <= '0;
         hold_ff <= '0;
      end else begin
         ver_ff  <= ver_in;
         ttl_ff  <= ttl_in;
         dest_ff <= dest_in;
         sum_ff  <= sum_in;
         hold_ff <= hold_in;
      end
   end

endmodule

### src/ipv4_header_check_core.sv
// ipv4_header_check_core: streaming ipv4 header validation, one byte per request
// a verdict reaches rsp once the last byte passes the item queue and the back stage
// throughput: one byte per cycle unless a full result queue stalls the back stage
// a front queue decouples byte tagging from header state; a result queue holds verdicts
// reset is synchronous: clears both queues, all per-packet state and local address to zero
// depends on ihc_pkg, ihc_fifo, ihc_front, ihc_back
module ipv4_header_check_core #(
   parameter int FRONT_DEPTH  = ihc_pkg::FRONT_QUEUE_DEPTH,
   parameter int RESULT_DEPTH = ihc_pkg::RESULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_packet_length,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import ihc_pkg::*;

   logic [31:0] local_address_ff, local_address_in;
   logic        req_accept;
   item_type    front_item, back_item;
   logic        front_empty;
   logic        back_pop;
   logic        res_full, res_push;
   result_type  back_result, rsp_result;

   assign req_accept       = req_push && !req_full;
   assign local_address_in = csr_write_enable ? csr_write_data : local_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
      end else begin
         local_address_ff <= local_address_in;
      end
   end

   ihc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .item      (front_item)
   );

   ihc_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (FRONT_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_item),
      .pop       (back_pop),
      .pop_data  (back_item),
      .full      (req_full),
      .empty     (front_empty)
   );

   ihc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item          (back_item),
      .item_valid    (!front_empty),
      .item_pop      (back_pop),
      .local_address (local_address_ff),
      .res_full      (res_full),
      .res_push      (res_push),
      .result        (back_result)
   );

   ihc_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (back_result),
      .pop       (rsp_pop),
      .pop_data  (rsp_result),
      .full      (res_full),
      .empty     (rsp_empty)
   );

   assign rsp_status        = rsp_result.status;
   assign rsp_packet_length = rsp_result.length;

`ifndef SYNTH
   a_result_no_overflow : assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   a_pop_needs_item : assert property (@(posedge clock) disable iff (reset)
      back_pop |-> !front_empty)
      else $error("back stage popped an empty item queue");

   a_empty_after_reset : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_status_legal : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status != 3'd7))
      else $error("illegal status code on result");
`endif

endmodule
